// ===== sv/m4inv_pkg.sv =====
// Shared constants, types and sequencer microcode for the 4x4 matrix inverse.
package m4inv_pkg;

	localparam int FracBitsDefault = 16;
	localparam int DataW = 32;
	localparam int ThrW = 31;
	localparam int IdxW = 4;
	// Widths that cover the exact products: 3x3 minor < 2^98, det < 2^131.
	localparam int MinW = 100;
	localparam int DetW = 134;

	// Sequencer opcodes.
	typedef enum logic [2:0] {
		OP_CLR  = 3'd0,
		OP_MUL2 = 3'd1,
		OP_MUL3 = 3'd2,
		OP_DETA = 3'd3,
		OP_DIV  = 3'd4,
		OP_EMIT = 3'd5,
		OP_JMP  = 3'd6,
		OP_END  = 3'd7
	} op_t;

	// Control word: opcode, accumulate sign, jump or product target.
	typedef struct packed {
		op_t        op;
		logic       neg;
		logic [3:0] tgt;
	} uword_t;

	// Program of one 3x3 minor and its use: clear, six two-term products into t0..t2,
	// three weighted sums, then det accumulation, division and emit. Step addresses are in uword().
	function automatic uword_t uword(input logic [3:0] pc);
		uword_t w;
		w = '{op: OP_END, neg: 1'b0, tgt: 4'd0};
		unique case (pc)
			4'd0:  w = '{op: OP_CLR,  neg: 1'b0, tgt: 4'd0};
			4'd1:  w = '{op: OP_MUL2, neg: 1'b0, tgt: 4'd0};
			4'd2:  w = '{op: OP_MUL2, neg: 1'b1, tgt: 4'd1};
			4'd3:  w = '{op: OP_MUL2, neg: 1'b0, tgt: 4'd2};
			4'd4:  w = '{op: OP_MUL2, neg: 1'b1, tgt: 4'd3};
			4'd5:  w = '{op: OP_MUL2, neg: 1'b0, tgt: 4'd4};
			4'd6:  w = '{op: OP_MUL2, neg: 1'b1, tgt: 4'd5};
			4'd7:  w = '{op: OP_MUL3, neg: 1'b0, tgt: 4'd0};
			4'd8:  w = '{op: OP_MUL3, neg: 1'b1, tgt: 4'd1};
			4'd9:  w = '{op: OP_MUL3, neg: 1'b0, tgt: 4'd2};
			4'd10: w = '{op: OP_DETA, neg: 1'b0, tgt: 4'd0};
			4'd11: w = '{op: OP_DIV,  neg: 1'b0, tgt: 4'd0};
			4'd12: w = '{op: OP_EMIT, neg: 1'b0, tgt: 4'd0};
			4'd13: w = '{op: OP_JMP,  neg: 1'b0, tgt: 4'd0};
			4'd14: w = '{op: OP_END,  neg: 1'b0, tgt: 4'd0};
			4'd15: w = '{op: OP_END,  neg: 1'b0, tgt: 4'd0};
		endcase
		return w;
	endfunction

	// Operand position for product slot s of a minor, as an index into the 3x3 list.
	function automatic logic [3:0] mpos(input logic [2:0] s, input logic b);
		logic [3:0] p;
		p = 4'd0;
		unique case ({s, b})
			4'b000_0: p = 4'd4; 4'b000_1: p = 4'd8;
			4'b001_0: p = 4'd5; 4'b001_1: p = 4'd7;
			4'b010_0: p = 4'd3; 4'b010_1: p = 4'd8;
			4'b011_0: p = 4'd5; 4'b011_1: p = 4'd6;
			4'b100_0: p = 4'd3; 4'b100_1: p = 4'd7;
			4'b101_0: p = 4'd4; 4'b101_1: p = 4'd6;
			default:  p = 4'd0;
		endcase
		return p;
	endfunction

	// Map an index into the 3x3 minor list to a stored position.
	function automatic logic [3:0] msel(input logic [3:0] n, input logic [1:0] sr,
			input logic [1:0] sc);
		logic [1:0] r, c;
		logic [3:0] rr, cc;
		rr = (n >= 4'd6) ? 4'd2 : ((n >= 4'd3) ? 4'd1 : 4'd0);
		cc = n - rr * 4'd3;
		r = rr[1:0] + ((rr[1:0] >= sr) ? 2'd1 : 2'd0);
		c = cc[1:0] + ((cc[1:0] >= sc) ? 2'd1 : 2'd0);
		return {r, c};
	endfunction

endpackage

// ===== sv/matrix_4x4_inverse_top.sv =====
// Top level of the 4x4 matrix inverse: store, microcoded sequencer, datapath.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------
//  element   | element_valid/ready     | element_value
//  result    | result_valid/ready      | result_value, result_index, singular, last_of_run
//  config    | cfg_we                  | cfg_wdata (singular threshold)
//
// Sixteen elements are loaded into the store. The microprogram then forms four determinant
// minors and, per result, one cofactor minor, a division step, an emit and a wait in the
// output register. Wide products go a limb at a time through a 32x33 multiplier. After
// its determinant, a singular matrix is sent back from the store element by element.
// Reset clears the load count, sequencer and threshold (to 1). A result waits in its
// output register while result_ready is low; the sequencer holds until it is taken.
module matrix_4x4_inverse_top #(
	parameter int FracBits = m4inv_pkg::FracBitsDefault
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        element_valid,
	output logic                        element_ready,
	input  logic signed [31:0]          element_value,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic signed [31:0]          result_value,
	output logic [3:0]                  result_index,
	output logic                        singular,
	output logic                        last_of_run,
	input  logic                        cfg_we,
	input  logic [30:0]                 cfg_wdata
);
	localparam int MinW = m4inv_pkg::MinW;
	localparam int DetW = m4inv_pkg::DetW;
	localparam int NumW = MinW + 2 * FracBits + 16;

	typedef enum logic [4:0] {
		ST_LOAD = 5'b00001,
		ST_RUN  = 5'b00010,
		ST_WAIT = 5'b00100,
		ST_DIVW = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [3:0]  load_q;
	logic [30:0] thr_q;
	logic [3:0]  pc_q;
	logic [2:0]  sub_q;      // operand within a two-term product step
	logic [4:0]  minor_q;    // 0..3 det minors, 4 or 5 for cofactors
	logic [3:0]  k_q;
	logic        sing_q;
	logic        rd_wait_q;
	logic [1:0]  ml_q;       // limb of the wide operand

	logic signed [MinW-1:0] t_q [3];
	logic signed [MinW-1:0] acc_q;
	logic signed [DetW-1:0] det_q;
	logic signed [DetW-1:0] mp_q;
	logic signed [31:0]     opa_q;
	logic signed [63:0]     prod;
	logic signed [MinW-1:0] mb;
	logic signed [32:0]     mlimb;
	logic signed [64:0]     mpart;
	logic signed [DetW-1:0] msum;
	logic                   m_more;
	logic signed [31:0]     ram_rd;
	logic [3:0]             raddr;
	logic [1:0]             sr, sc;
	m4inv_pkg::uword_t      uw;
	logic                   div_start, div_busy;
	logic signed [31:0]     div_quot;
	logic [DetW-1:0]        det_abs;
	logic [NumW-1:0]        num_abs;
	logic signed [MinW-1:0] cof;
	logic [DetW-1:0]        limit;

	assign uw = m4inv_pkg::uword(pc_q);
	assign element_ready = (state_q == ST_LOAD);

	// Skip row/col for the current minor: det minors skip row 0, col j;
	// cofactor k=4r+c skips row c, col r.
	always_comb begin
		if (minor_q < 5'd4) begin
			sr = 2'd0;
			sc = minor_q[1:0];
		end else begin
			sr = k_q[1:0];
			sc = k_q[3:2];
		end
	end

	// Read address per step: two-term products read two operands, sums read
	// the row-0 minor element; det accumulation reads stored row 0, emit reads element k.
	always_comb begin
		raddr = 4'd0;
		unique case (uw.op)
			m4inv_pkg::OP_MUL2: raddr = m4inv_pkg::msel(
				m4inv_pkg::mpos(3'(pc_q - 4'd1), sub_q[0]), sr, sc);
			m4inv_pkg::OP_MUL3: raddr = m4inv_pkg::msel(4'(pc_q - 4'd7), sr, sc);
			m4inv_pkg::OP_DETA: raddr = {2'd0, minor_q[1:0]};
			m4inv_pkg::OP_EMIT: raddr = k_q;
			default:            raddr = 4'd0;
		endcase
		if (state_q == ST_LOAD) raddr = 4'd0;
	end

	m4inv_ram #(.Width(32), .Depth(16)) u_store (
		.clk   (clk),
		.we    (element_valid && element_ready),
		.waddr (load_q),
		.wdata (element_value),
		.raddr (raddr),
		.rdata (ram_rd)
	);

	// Two stored elements for the t terms.
	assign prod = opa_q * ram_rd;

	// A stored element times a wide term (t or minor), one 32-bit limb per cycle;
	// the top limb carries the sign.
	always_comb begin
		mb = (uw.op == m4inv_pkg::OP_MUL3) ? t_q[2'(pc_q - 4'd7)] : acc_q;
		unique case (ml_q)
			2'd0: mlimb = {1'b0, mb[31:0]};
			2'd1: mlimb = {1'b0, mb[63:32]};
			2'd2: mlimb = {1'b0, mb[95:64]};
			2'd3: mlimb = {{(129 - MinW){mb[MinW-1]}}, mb[MinW-1:96]};
		endcase
	end

	assign mpart  = ram_rd * mlimb;
	assign msum   = ((ml_q == 2'd0) ? {DetW{1'b0}} : mp_q) + (DetW'(mpart) <<< {ml_q, 5'd0});
	assign m_more = ((uw.op == m4inv_pkg::OP_MUL3) ||
		((uw.op == m4inv_pkg::OP_DETA) && (minor_q < 5'd4))) && (ml_q != 2'd3);

	assign cof     = (sr[0] ^ sc[0]) ? -acc_q : acc_q;
	assign det_abs = det_q[DetW-1] ? DetW'(-det_q) : DetW'(det_q);
	assign num_abs = NumW'(cof[MinW-1] ? -cof : cof) << (2 * FracBits);
	assign limit   = DetW'(thr_q) << (3 * FracBits);
	assign div_start = (state_q == ST_RUN) && !rd_wait_q && (uw.op == m4inv_pkg::OP_DIV) &&
		!sing_q;

	m4inv_div #(.NumW(NumW), .DenW(DetW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_abs),
		.den    (det_abs),
		.neg    (cof[MinW-1] ^ det_q[DetW-1]),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 31'd1;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			load_q       <= '0;
			pc_q         <= '0;
			sub_q        <= '0;
			minor_q      <= '0;
			k_q          <= '0;
			sing_q       <= 1'b0;
			rd_wait_q    <= 1'b0;
			ml_q         <= '0;
			result_valid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (element_valid) begin
						load_q <= load_q + 1'b1;
						if (load_q == 4'd15) begin
							state_q   <= ST_RUN;
							pc_q      <= '0;
							minor_q   <= '0;
							k_q       <= '0;
							sing_q    <= 1'b0;
							rd_wait_q <= 1'b1;
							ml_q      <= '0;
						end
					end
				end
				ST_RUN: begin
					// Every read step puts out the address, then uses the registered data.
					// Hold the data while the limbs of a wide product go through.
					if (rd_wait_q) begin
						rd_wait_q <= 1'b0;
					end else begin
						rd_wait_q <= !m_more;
						unique case (uw.op)
							m4inv_pkg::OP_CLR: begin
								sub_q <= '0;
								if ((minor_q == 5'd4) && ((det_q == '0) || (det_abs < limit)))
								begin
									sing_q <= 1'b1;
									pc_q   <= 4'd12;
								end else begin
									pc_q <= pc_q + 1'b1;
								end
							end
							m4inv_pkg::OP_MUL2: begin
								if (!sub_q[0]) begin
									opa_q <= ram_rd;
									sub_q <= 3'd1;
								end else begin
									sub_q <= '0;
									pc_q  <= pc_q + 1'b1;
									if (uw.neg)
										t_q[uw.tgt[2:1]] <= t_q[uw.tgt[2:1]] - MinW'(prod);
									else
										t_q[uw.tgt[2:1]] <= MinW'(prod);
								end
							end
							m4inv_pkg::OP_MUL3: begin
								if (ml_q != 2'd3) begin
									ml_q <= ml_q + 1'b1;
									mp_q <= msum;
								end else begin
									ml_q <= '0;
									pc_q <= pc_q + 1'b1;
									if (uw.tgt == 4'd0)  acc_q <= MinW'(msum);
									else if (uw.neg)     acc_q <= acc_q - MinW'(msum);
									else                 acc_q <= acc_q + MinW'(msum);
								end
							end
							m4inv_pkg::OP_DETA: begin
								if (minor_q < 5'd4) begin
									if (ml_q != 2'd3) begin
										ml_q <= ml_q + 1'b1;
										mp_q <= msum;
									end else begin
										ml_q <= '0;
										if (minor_q == 5'd0)
											det_q <= msum;
										else if (minor_q[0])
											det_q <= det_q - msum;
										else
											det_q <= det_q + msum;
										minor_q <= minor_q + 1'b1;
										pc_q    <= '0;
									end
								end else begin
									pc_q <= pc_q + 1'b1;
								end
							end
							m4inv_pkg::OP_DIV: begin
								pc_q  <= pc_q + 1'b1;
								state_q <= sing_q ? ST_RUN : ST_DIVW;
							end
							m4inv_pkg::OP_EMIT: begin
								result_index <= k_q;
								singular     <= sing_q;
								last_of_run  <= (k_q == 4'd15);
								result_value <= sing_q ? ram_rd : div_quot;
								result_valid <= 1'b1;
								state_q      <= ST_OUT;
							end
							m4inv_pkg::OP_JMP: begin
								pc_q <= uw.tgt;
							end
							m4inv_pkg::OP_END: begin
								state_q <= ST_LOAD;
							end
						endcase
					end
				end
				ST_DIVW: begin
					if (!div_busy && !div_start) begin
						state_q   <= ST_RUN;
						rd_wait_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (result_ready) begin
						result_valid <= 1'b0;
						rd_wait_q    <= 1'b1;
						if (k_q == 4'd15) begin
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_RUN;
							if (sing_q) begin
								pc_q <= 4'd12;
							end else begin
								pc_q    <= '0;
								minor_q <= 5'd5;
							end
						end
					end
				end
				ST_WAIT: state_q <= ST_RUN;
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// The divider only runs inside its wait state.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_DIVW)) else $error("divider busy outside wait");
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (state_q == ST_OUT)) else $error("result shown outside output");
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_of_run) |-> (result_index == 4'd15))
		else $error("last mark off index 15");
	assert property (@(posedge clk) disable iff (!arst_n)
		element_ready |-> !result_valid) else $error("load while result pending");
endmodule

// ===== sv/m4inv_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module m4inv_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/m4inv_div.sv =====
// Bit-serial restoring divider for saturated Q quotients.
module m4inv_div #(
	parameter int NumW = 164,
	parameter int DenW = 134
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [NumW-1:0]        num,
	input  logic [DenW-1:0]        den,
	input  logic                   neg,
	output logic                   busy,
	output logic signed [31:0]     quot
);
	localparam int CntW = $clog2(NumW + 1);
	localparam int QkW = NumW - 31;

	logic [CntW-1:0] cnt_q;
	logic [NumW-1:0] num_q;
	logic [DenW:0]   rem_q;
	logic [DenW-1:0] den_q;
	logic [QkW-1:0]  qhi_q;
	logic [31:0]     qlo_q;
	logic            neg_q;
	logic [DenW:0]   trial;
	logic [DenW:0]   shifted;
	logic            take;

	assign shifted = {rem_q[DenW-1:0], num_q[NumW-1]};
	assign take    = shifted >= {1'b0, den_q};
	assign trial   = take ? shifted - {1'b0, den_q} : shifted;
	assign busy    = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(NumW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			qhi_q <= '0;
			qlo_q <= '0;
			neg_q <= neg;
		end else if (busy) begin
			num_q <= {num_q[NumW-2:0], 1'b0};
			rem_q <= trial;
			{qhi_q, qlo_q} <= {qhi_q[QkW-2:0], qlo_q, take};
		end
	end

	// Saturate the magnitude into the signed 32-bit range.
	always_comb begin
		if (neg_q) begin
			if (qhi_q != '0 || qlo_q > 32'h8000_0000) quot = 32'sh8000_0000;
			else quot = -$signed(qlo_q);
		end else begin
			if (qhi_q != '0 || qlo_q[31]) quot = 32'sh7FFF_FFFF;
			else quot = $signed(qlo_q);
		end
	end
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the 4x4 matrix inverse: random and directed matrices, exact prediction.
module tb;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic signed [31:0] value;
		logic [3:0]         index;
		logic               sing;
		logic               last;
	} inv_result_t;

	class inverse_board;
		logic signed [31:0] store[16];
		int unsigned        fill;
		logic [30:0]        thr;
		inv_result_t        pending[$];

		function new();
			fill = 0;
			thr = 31'd1;
			foreach (store[i]) store[i] = '0;
		endfunction

		// 3x3 determinant of the store without row sr and column sc
		function wide_t minor3(int sr, int sc);
			wide_t v[9];
			int n;
			n = 0;
			for (int r = 0; r < 4; r++) begin
				if (r == sr) continue;
				for (int c = 0; c < 4; c++) begin
					if (c == sc) continue;
					v[n] = store[r * 4 + c];
					n++;
				end
			end
			return v[0] * (v[4] * v[8] - v[5] * v[7])
				- v[1] * (v[3] * v[8] - v[5] * v[6])
				+ v[2] * (v[3] * v[7] - v[4] * v[6]);
		endfunction

		function void note_element(logic signed [31:0] v);
			wide_t det, mag, lim, cof, q;
			logic sing;
			inv_result_t e;
			store[fill] = v;
			if (fill < 15) begin
				fill++;
				return;
			end
			fill = 0;
			det = '0;
			for (int j = 0; j < 4; j++) begin
				if (j % 2 == 0) det = det + store[j] * minor3(0, j);
				else det = det - store[j] * minor3(0, j);
			end
			mag = (det < 0) ? -det : det;
			lim = {225'd0, thr};
			lim = lim << (3 * m4inv_pkg::FracBitsDefault);
			sing = (det == 0) || (mag < lim);
			for (int k = 0; k < 16; k++) begin
				e.index = k[3:0];
				e.sing = sing;
				e.last = (k == 15);
				if (sing) begin
					e.value = store[k];
				end else begin
					cof = minor3(k % 4, k / 4);
					if (((k / 4) + (k % 4)) % 2 == 1) cof = -cof;
					q = (cof <<< (2 * m4inv_pkg::FracBitsDefault)) / det;
					if (q > 256'sh7FFFFFFF) e.value = 32'sh7FFFFFFF;
					else if (q < -256'sh80000000) e.value = 32'sh80000000;
					else e.value = q[31:0];
				end
				pending.push_back(e);
			end
		endfunction

		function string check_result(logic signed [31:0] value, logic [3:0] index,
				logic sing, logic last);
			inv_result_t e;
			if (pending.size() == 0)
				return $sformatf("unexpected result idx %0d value %h", index, value);
			e = pending.pop_front();
			if (value !== e.value || index !== e.index || sing !== e.sing || last !== e.last)
				return $sformatf("idx %0d/%0d value %h/%h singular %b/%b last %b/%b (got/exp)",
					index, e.index, value, e.value, sing, e.sing, last, e.last);
			return "";
		endfunction
	endclass

	localparam int WatchLimit = 40000;

	logic               clk;
	logic               arst_n;
	logic               element_valid;
	logic               element_ready;
	logic signed [31:0] element_value;
	logic               result_valid;
	logic               result_ready;
	logic signed [31:0] result_value;
	logic [3:0]         result_index;
	logic               singular;
	logic               last_of_run;
	logic               cfg_we;
	logic [30:0]        cfg_wdata;

	inverse_board board;
	int errors;
	int tx_idle;
	int rx_stall;
	int idle_cycles;
	int n_elements;
	int n_results;
	int n_singular;

	matrix_4x4_inverse_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.element_valid(element_valid),
		.element_ready(element_ready),
		.element_value(element_value),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_value(result_value),
		.result_index(result_index),
		.singular(singular),
		.last_of_run(last_of_run),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	// check each result transfer, then pick the next ready
	always @(posedge clk) begin
		string msg;
		if (arst_n && result_valid && result_ready) begin
			msg = board.check_result(result_value, result_index, singular, last_of_run);
			if (msg != "") report(msg);
			n_results++;
			if (singular) n_singular++;
		end
		result_ready <= ($urandom_range(99) >= rx_stall);
	end

	always @(posedge clk) begin
		if (!arst_n || (element_valid && element_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("watchdog: no transfer for %0d cycles", WatchLimit);
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic send_element(logic signed [31:0] v);
		if ($urandom_range(99) < tx_idle) begin
			element_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle);
		end
		element_valid <= 1'b1;
		element_value <= v;
		do @(posedge clk); while (!(element_valid && element_ready));
		board.note_element(v);
		n_elements++;
	endtask

	task automatic drain();
		element_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		// let the sequencer finish its last steps
		repeat (60) @(posedge clk);
	endtask

	task automatic set_threshold(logic [30:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.thr = v;
	endtask

	function automatic logic signed [31:0] small_val(int span);
		return $signed($urandom_range(2 * span)) - span;
	endfunction

	task automatic send_matrix(int kind);
		logic signed [31:0] m[16];
		for (int i = 0; i < 16; i++) begin
			case (kind)
				0: m[i] = $urandom;
				1, 3: m[i] = small_val(1 << 18);
				2: m[i] = (i % 5 == 0) ? 32'($urandom_range(8, 1) << 16) : small_val(1 << 13);
				default: m[i] = small_val(256);
			endcase
		end
		// duplicate a row to make the matrix exactly singular
		if (kind == 3)
			for (int c = 0; c < 4; c++) m[8 + c] = m[c];
		foreach (m[i]) send_element(m[i]);
	endtask

	initial begin
		board = new();
		n_elements = 0;
		tx_idle = 0;
		rx_stall = 0;
		arst_n = 1'b0;
		element_valid <= 1'b0;
		element_value <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// diagonal of extremes: saturating inverse of both signs
		for (int i = 0; i < 16; i++)
			case (i)
				0: send_element(32'sd1);
				5: send_element(-32'sd1);
				10: send_element(32'sh7FFFFFFF);
				15: send_element(32'sh80000000);
				default: send_element(32'sd0);
			endcase
		// all-zero matrix: zero determinant
		repeat (16) send_element(32'sd0);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin tx_idle = 0; rx_stall = 0; end
				1: begin tx_idle = 74; rx_stall = 0; set_threshold(31'd0); end
				2: begin tx_idle = 0; rx_stall = 74; set_threshold(31'h7FFFFFFF); end
				3: begin
					tx_idle = 25; rx_stall = 25;
					set_threshold(31'($urandom_range(16, 0)));
				end
				default: begin
					tx_idle = 0; rx_stall = 0;
					set_threshold(31'($urandom_range(31'h7FFFFFFF, 0)));
				end
			endcase
			for (int n = 0; n < ((ph == 0) ? 6 : 5); n++) send_matrix($urandom_range(4));
			if (ph == 1) send_matrix(3);
		end
		drain();

		$display("covered %0d elements, %0d results (%0d singular), 5 threshold settings",
			n_elements, n_results, n_singular);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
